@@ src/lattice_median_outlier_test_assert.svh @@
// Assertion macros for the lattice median outlier test.
// Used by src/lattice_median_outlier_test.sv; expects clk and rst_n in scope.
`ifndef LATTICE_MEDIAN_OUTLIER_TEST_ASSERT_SVH
`define LATTICE_MEDIAN_OUTLIER_TEST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LMOT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmot implication failed");

// Next-cycle implication, disabled during reset.
`define LMOT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmot next-cycle check failed");

`endif

@@ src/lmot_pkg.sv @@
// Shared constants, types and helpers of the lattice median outlier test.
// No dependencies; imported by the top level and the testbench.
package lmot_pkg;
  localparam int MAX_W     = 32;
  localparam int COL_W     = $clog2(MAX_W);
  localparam int DEPTH     = 3 * MAX_W;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DISP_W    = 24;
  localparam int SCORE_W   = 16;
  localparam int ROW_W     = 16;
  localparam int CNT_W     = 22;
  localparam int TOL_W     = 23;
  localparam int WCFG_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NB        = 8;
  localparam int NB_W      = $clog2(NB + 1);
  localparam int MIN_NB    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VLIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OLIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd4;

  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [1:0] slot_t;

  // Neighbor k as {row code, col code}: 0 = minus one, 1 = same, 2 = plus one.
  function automatic logic [3:0] nb_off(input logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd0: r = {2'd0, 2'd0};
      3'd1: r = {2'd0, 2'd1};
      3'd2: r = {2'd0, 2'd2};
      3'd3: r = {2'd1, 2'd0};
      3'd4: r = {2'd1, 2'd2};
      3'd5: r = {2'd2, 2'd0};
      3'd6: r = {2'd2, 2'd1};
      default: r = {2'd2, 2'd2};
    endcase
    return r;
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic slot_t slot_dec(input slot_t s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input slot_t s, input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_W) + ADDR_W'(c));
  endfunction
endpackage

@@ src/lmot_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/lattice_median_outlier_test.sv @@
// Top level of the lattice median outlier test (3x3 neighbor median check).
// Depends on lmot_pkg, lmot_ram and lattice_median_outlier_test_assert.svh.
//
//  Channel | Direction | Handshake          | Word
//  in_     | input     | in_valid/in_ready  | disp_u, disp_v, corr_score, node_solved
//  out_    | output    | out_valid/out_ready| node_row/col, kept, output_ok, counts, last
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// An input word is taken only while the sequencer is idle. It then decides 0, 1
// or 2 nodes, and the final word of the lattice decides a whole row more.
// Each decision runs the gather state through the single read port of the
// displacement RAM, the rank unit one neighbor at a time (skipped with too few
// neighbors), a check state and the load of the output register.
// Reset (rst_n low, synchronous) clears control state, counts and vertex flags.
// A stalled output holds the sequencer in its emit step; no word is ever dropped.
module lattice_median_outlier_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lmot_pkg::disp_t               in_disp_u,
  input  lmot_pkg::disp_t               in_disp_v,
  input  logic [lmot_pkg::SCORE_W-1:0]  in_corr_score,
  input  logic                          in_node_solved,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lmot_pkg::ROW_W-1:0]    out_node_row,
  output logic [lmot_pkg::COL_W-1:0]    out_node_col,
  output logic                          out_kept,
  output logic                          out_output_ok,
  output logic [lmot_pkg::CNT_W-1:0]    out_kept_count,
  output logic [lmot_pkg::CNT_W-1:0]    out_output_count,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [lmot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmot_pkg::TOL_W-1:0]    cfg_wdata
);
  import lmot_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_GATH  = 3'd2;
  localparam logic [2:0] S_MED   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [1:0] J_A = 2'd0;  // node above-left of the input
  localparam logic [1:0] J_B = 2'd1;  // node directly above, at row end
  localparam logic [1:0] J_F = 2'd2;  // final-row flush

  // Configuration registers
  logic [WCFG_W-1:0]  cfg_w_r;
  logic [ROW_W-1:0]   cfg_h_r;
  logic [SCORE_W-1:0] vlim_r, olim_r;
  logic [TOL_W-1:0]   tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= WCFG_W'(2);
      cfg_h_r <= ROW_W'(2);
      vlim_r  <= '0;
      olim_r  <= '0;
      tol_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg_w_r <= cfg_wdata[WCFG_W-1:0];
        REG_HEIGHT: cfg_h_r <= cfg_wdata[ROW_W-1:0];
        REG_VLIM:   vlim_r  <= cfg_wdata[SCORE_W-1:0];
        REG_OLIM:   olim_r  <= cfg_wdata[SCORE_W-1:0];
        REG_TOL:    tol_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective lattice size: width clamped to 2..MAX_W, height at least 2
  logic [WCFG_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  assign w_eff = (cfg_w_r < WCFG_W'(2)) ? WCFG_W'(2) :
                 (cfg_w_r > WCFG_W'(MAX_W)) ? WCFG_W'(MAX_W) : cfg_w_r;
  assign h_eff = (cfg_h_r < ROW_W'(2)) ? ROW_W'(2) : cfg_h_r;

  // Sequencer state
  logic [2:0]         state_r, state_nxt;
  logic [ROW_W-1:0]   pos_row_r, pos_row_nxt;
  logic [COL_W-1:0]   pos_col_r, pos_col_nxt;
  slot_t              pos_slot_r, pos_slot_nxt;
  logic [ROW_W-1:0]   crow_r, crow_nxt;
  logic [COL_W-1:0]   ccol_r, ccol_nxt;
  slot_t              cslot_r, cslot_nxt;
  logic               cfinal_r, cfinal_nxt;
  logic [COL_W-1:0]   wm1_r, wm1_nxt;
  logic [ROW_W-1:0]   hm1_r, hm1_nxt;
  logic [1:0]         jkind_r, jkind_nxt;
  logic [ROW_W-1:0]   jrow_r, jrow_nxt;
  logic [COL_W-1:0]   jcol_r, jcol_nxt;
  slot_t              jslot_r, jslot_nxt;
  logic               jlast_r, jlast_nxt;
  logic [3:0]         g_r, g_nxt;
  logic [NB_W-1:0]    nn_r, nn_nxt;
  logic [2:0]         mi_r, mi_nxt;
  logic               pend_nb_r, pend_nb_nxt;
  logic               pend_self_r, pend_self_nxt;
  disp_t              nu_r [NB];
  disp_t              nv_r [NB];
  disp_t              su_r, sv_r, medu_r, medv_r;
  disp_t              medu_nxt, medv_nxt;
  logic               kept_r, kept_nxt, outok_r, outok_nxt;
  logic [CNT_W-1:0]   ktot_r, ktot_nxt, otot_r, otot_nxt;
  logic [DEPTH-1:0]   vflag_r, vflag_nxt, oflag_r, oflag_nxt;

  // Output register
  logic               ovalid_r, ovalid_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic [COL_W-1:0]   ocol_r, ocol_nxt;
  logic               okept_r, okept_nxt, ook_r, ook_nxt, olast_r, olast_nxt;
  logic [CNT_W-1:0]   okc_r, okc_nxt, ooc_r, ooc_nxt;

  // Displacement RAM, u in the upper half, v in the lower half
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [2*DISP_W-1:0]   ram_rdata;

  lmot_ram #(.WIDTH(2 * DISP_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_disp_u, in_disp_v}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic              accept;
  logic              restart;
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  slot_t             a_slot;
  logic [ADDR_W-1:0] me_addr, nb_addr;
  logic [3:0]        off;
  logic              nb_in, nb_ok;
  logic [COL_W-1:0]  nb_col;
  slot_t             nb_slot;
  logic              out_free;
  logic [NB_W-1:0]   mk;
  logic [NB_W-1:0]   lt_u, le_u, lt_v, le_v;
  disp_t             cu, cv;
  logic signed [DISP_W:0] du, dv;
  logic [DISP_W:0]   au, av;
  logic              far_u, far_v;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !ovalid_r || out_ready;

  // Restart when the stored position lies outside the current lattice
  assign restart = ({1'b0, pos_col_r} >= w_eff) || (pos_row_r >= h_eff);
  assign a_row   = restart ? '0 : pos_row_r;
  assign a_col   = restart ? '0 : pos_col_r;
  assign a_slot  = restart ? '0 : pos_slot_r;

  assign ram_we    = accept;
  assign ram_waddr = cell_addr(a_slot, a_col);

  // Neighbor address generation for gather step g
  assign me_addr = cell_addr(jslot_r, jcol_r);
  assign off     = nb_off(g_r[2:0]);
  assign nb_slot = (off[3:2] == 2'd0) ? slot_dec(jslot_r) :
                   (off[3:2] == 2'd2) ? slot_inc(jslot_r) : jslot_r;
  assign nb_col  = COL_W'(jcol_r + COL_W'(off[1:0]) - COL_W'(1));
  assign nb_in   = !((off[3:2] == 2'd0) && (jrow_r == '0)) &&
                   !((off[3:2] == 2'd2) && (jrow_r == hm1_r)) &&
                   !((off[1:0] == 2'd0) && (jcol_r == '0)) &&
                   !((off[1:0] == 2'd2) && (jcol_r == wm1_r));
  assign nb_addr = cell_addr(nb_slot, nb_col);
  assign nb_ok   = nb_in && vflag_r[nb_addr];
  assign ram_raddr = (g_r == 4'd8) ? me_addr : nb_addr;

  // Rank unit: candidate mi against all gathered values, u and v side by side
  assign mk = nn_r >> 1;
  assign cu = nu_r[mi_r];
  assign cv = nv_r[mi_r];
  always_comb begin
    lt_u = '0; le_u = '0; lt_v = '0; le_v = '0;
    for (int j = 0; j < NB; j++) begin
      if (NB_W'(j) < nn_r) begin
        lt_u = lt_u + NB_W'(nu_r[j] <  cu);
        le_u = le_u + NB_W'(nu_r[j] <= cu);
        lt_v = lt_v + NB_W'(nv_r[j] <  cv);
        le_v = le_v + NB_W'(nv_r[j] <= cv);
      end
    end
  end

  // Deviation check
  assign du    = (DISP_W+1)'(su_r) - (DISP_W+1)'(medu_r);
  assign dv    = (DISP_W+1)'(sv_r) - (DISP_W+1)'(medv_r);
  assign au    = du[DISP_W] ? (DISP_W+1)'(-du) : du;
  assign av    = dv[DISP_W] ? (DISP_W+1)'(-dv) : dv;
  assign far_u = au > (DISP_W+1)'(tol_r);
  assign far_v = av > (DISP_W+1)'(tol_r);

  always_comb begin
    state_nxt     = state_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    pos_slot_nxt  = pos_slot_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    cslot_nxt     = cslot_r;
    cfinal_nxt    = cfinal_r;
    wm1_nxt       = wm1_r;
    hm1_nxt       = hm1_r;
    jkind_nxt     = jkind_r;
    jrow_nxt      = jrow_r;
    jcol_nxt      = jcol_r;
    jslot_nxt     = jslot_r;
    jlast_nxt     = jlast_r;
    g_nxt         = g_r;
    nn_nxt        = nn_r;
    mi_nxt        = mi_r;
    pend_nb_nxt   = 1'b0;
    pend_self_nxt = 1'b0;
    medu_nxt      = medu_r;
    medv_nxt      = medv_r;
    kept_nxt      = kept_r;
    outok_nxt     = outok_r;
    ktot_nxt      = ktot_r;
    otot_nxt      = otot_r;
    vflag_nxt     = vflag_r;
    oflag_nxt     = oflag_r;
    ovalid_nxt    = ovalid_r && !out_ready;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    okept_nxt     = okept_r;
    ook_nxt       = ook_r;
    olast_nxt     = olast_r;
    okc_nxt       = okc_r;
    ooc_nxt       = ooc_r;

    // Gathered neighbor data arrives in the cycle after its read
    if (pend_nb_r) begin
      nn_nxt = nn_r + NB_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          vflag_nxt[ram_waddr] = in_node_solved && (in_corr_score <= vlim_r);
          oflag_nxt[ram_waddr] = in_corr_score <= olim_r;
          crow_nxt   = a_row;
          ccol_nxt   = a_col;
          cslot_nxt  = a_slot;
          wm1_nxt    = COL_W'(w_eff - WCFG_W'(1));
          hm1_nxt    = h_eff - ROW_W'(1);
          cfinal_nxt = (a_row == h_eff - ROW_W'(1)) &&
                       ({1'b0, a_col} == w_eff - WCFG_W'(1));
          if ((a_row == '0) && (a_col == '0)) begin
            ktot_nxt = '0;
            otot_nxt = '0;
          end
          // Advance the input position
          if (cfinal_nxt) begin
            pos_row_nxt  = '0;
            pos_col_nxt  = '0;
            pos_slot_nxt = '0;
          end else if ({1'b0, a_col} == w_eff - WCFG_W'(1)) begin
            pos_row_nxt  = a_row + ROW_W'(1);
            pos_col_nxt  = '0;
            pos_slot_nxt = slot_inc(a_slot);
          end else begin
            pos_row_nxt  = a_row;
            pos_col_nxt  = a_col + COL_W'(1);
            pos_slot_nxt = a_slot;
          end
          state_nxt = S_START;
        end
      end
      S_START: begin
        if ((crow_r != '0) && (ccol_r != '0)) begin
          jkind_nxt = J_A;
          jrow_nxt  = crow_r - ROW_W'(1);
          jcol_nxt  = ccol_r - COL_W'(1);
          jslot_nxt = slot_dec(cslot_r);
          jlast_nxt = 1'b0;
          g_nxt     = '0;
          nn_nxt    = '0;
          state_nxt = S_GATH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_GATH: begin
        pend_nb_nxt   = (g_r < 4'd8) && nb_ok;
        pend_self_nxt = (g_r == 4'd8);
        g_nxt         = g_r + 4'd1;
        mi_nxt        = '0;
        if (g_r == 4'd9) begin
          if (vflag_r[me_addr] && (nn_r >= NB_W'(MIN_NB))) begin
            state_nxt = S_MED;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_MED: begin
        if ((lt_u <= mk) && (mk < le_u)) begin
          medu_nxt = cu;
        end
        if ((lt_v <= mk) && (mk < le_v)) begin
          medv_nxt = cv;
        end
        mi_nxt = mi_r + 3'd1;
        if (NB_W'(mi_r) == nn_r - NB_W'(1)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        kept_nxt  = vflag_r[me_addr] &&
                    ((nn_r < NB_W'(MIN_NB)) || !(far_u || far_v));
        outok_nxt = kept_nxt && oflag_r[me_addr];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ktot_nxt   = ktot_r + CNT_W'(kept_r);
          otot_nxt   = otot_r + CNT_W'(outok_r);
          ovalid_nxt = 1'b1;
          orow_nxt   = jrow_r;
          ocol_nxt   = jcol_r;
          okept_nxt  = kept_r;
          ook_nxt    = outok_r;
          olast_nxt  = jlast_r;
          okc_nxt    = ktot_nxt;
          ooc_nxt    = otot_nxt;
          // Pick the next decision of this word, if any
          g_nxt     = '0;
          nn_nxt    = '0;
          state_nxt = S_GATH;
          case (jkind_r)
            J_A: begin
              if (ccol_r == wm1_r) begin
                jkind_nxt = J_B;
                jcol_nxt  = ccol_r;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            J_B: begin
              if (cfinal_r) begin
                jkind_nxt = J_F;
                jrow_nxt  = crow_r;
                jcol_nxt  = '0;
                jslot_nxt = cslot_r;
                jlast_nxt = 1'b0;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            default: begin
              if (jcol_r == wm1_r) begin
                state_nxt = S_IDLE;
              end else begin
                jcol_nxt  = jcol_r + COL_W'(1);
                jlast_nxt = (jcol_r + COL_W'(1)) == wm1_r;
              end
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      pos_slot_r  <= '0;
      ktot_r      <= '0;
      otot_r      <= '0;
      vflag_r     <= '0;
      oflag_r     <= '0;
      ovalid_r    <= 1'b0;
      pend_nb_r   <= 1'b0;
      pend_self_r <= 1'b0;
      g_r         <= '0;
      nn_r        <= '0;
      mi_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      pos_slot_r  <= pos_slot_nxt;
      ktot_r      <= ktot_nxt;
      otot_r      <= otot_nxt;
      vflag_r     <= vflag_nxt;
      oflag_r     <= oflag_nxt;
      ovalid_r    <= ovalid_nxt;
      pend_nb_r   <= pend_nb_nxt;
      pend_self_r <= pend_self_nxt;
      g_r         <= g_nxt;
      nn_r        <= nn_nxt;
      mi_r        <= mi_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    crow_r   <= crow_nxt;
    ccol_r   <= ccol_nxt;
    cslot_r  <= cslot_nxt;
    cfinal_r <= cfinal_nxt;
    wm1_r    <= wm1_nxt;
    hm1_r    <= hm1_nxt;
    jkind_r  <= jkind_nxt;
    jrow_r   <= jrow_nxt;
    jcol_r   <= jcol_nxt;
    jslot_r  <= jslot_nxt;
    jlast_r  <= jlast_nxt;
    medu_r   <= medu_nxt;
    medv_r   <= medv_nxt;
    kept_r   <= kept_nxt;
    outok_r  <= outok_nxt;
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
    okept_r  <= okept_nxt;
    ook_r    <= ook_nxt;
    olast_r  <= olast_nxt;
    okc_r    <= okc_nxt;
    ooc_r    <= ooc_nxt;
    if (pend_nb_r) begin
      nu_r[nn_r[2:0]] <= ram_rdata[2*DISP_W-1:DISP_W];
      nv_r[nn_r[2:0]] <= ram_rdata[DISP_W-1:0];
    end
    if (pend_self_r) begin
      su_r <= ram_rdata[2*DISP_W-1:DISP_W];
      sv_r <= ram_rdata[DISP_W-1:0];
    end
  end

  assign out_valid        = ovalid_r;
  assign out_node_row     = orow_r;
  assign out_node_col     = ocol_r;
  assign out_kept         = okept_r;
  assign out_output_ok    = ook_r;
  assign out_kept_count   = okc_r;
  assign out_output_count = ooc_r;
  assign out_last         = olast_r;

  `include "lattice_median_outlier_test_assert.svh"

  // The rank unit only runs with enough neighbors for a median
  `LMOT_ASSERT_IMPL(a_med_enough, state_r == S_MED, nn_r >= NB_W'(MIN_NB))
  // A last word is always the rightmost node of the flushed row
  `LMOT_ASSERT_IMPL(a_last_col, (state_r == S_EMIT) && jlast_r,
                    (jcol_r == wm1_r) && (jkind_r == J_F))
  // A decision loaded into a free output register shows up as valid
  `LMOT_ASSERT_NEXT(a_emit_load, (state_r == S_EMIT) && out_free, out_valid)
  // Never more than eight neighbors are collected
  `LMOT_ASSERT_IMPL(a_nn_bound, 1'b1, nn_r <= NB_W'(NB))
endmodule

@@ tb/lattice_median_outlier_test_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lattice_median_outlier_test: directed and random lattices.
// Depends on lmot_pkg and the RTL top level only.
module lattice_median_outlier_test_tb;
  import lmot_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int ITEM_TARGET    = 370;

  // One input word and one decided-node word.
  typedef struct packed {
    logic [DISP_W-1:0]  u;
    logic [DISP_W-1:0]  v;
    logic [SCORE_W-1:0] score;
    logic               solved;
  } node_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             kept;
    logic             ok;
    logic [CNT_W-1:0] kcnt;
    logic [CNT_W-1:0] ocnt;
    logic             last;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  disp_t in_disp_u = '0;
  disp_t in_disp_v = '0;
  logic [SCORE_W-1:0] in_corr_score = '0;
  logic in_node_solved = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROW_W-1:0] out_node_row;
  logic [COL_W-1:0] out_node_col;
  logic out_kept, out_output_ok, out_last;
  logic [CNT_W-1:0] out_kept_count, out_output_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [TOL_W-1:0] cfg_wdata = '0;

  lattice_median_outlier_test DUT (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block: configuration, three-row store, position, totals.
  logic [WCFG_W-1:0]  lat_w_reg;
  logic [ROW_W-1:0]   lat_h_reg;
  logic [SCORE_W-1:0] vert_lim, outp_lim;
  logic [TOL_W-1:0]   tol_reg;
  int                 sh_u [DEPTH];
  int                 sh_v [DEPTH];
  bit                 sh_vert [DEPTH];
  bit                 sh_outp [DEPTH];
  int unsigned        pos_row, pos_col;
  logic [CNT_W-1:0]   kept_run, outp_run;

  node_word_t pending_words[$];
  decision_t  expected_nodes[$];
  int         words_queued = 0, words_taken = 0, nodes_seen = 0;
  int         mismatches = 0, phases_run = 0;

  function automatic int unsigned width_eff();
    if (lat_w_reg < 2) return 2;
    if (lat_w_reg > MAX_W) return MAX_W;
    return lat_w_reg;
  endfunction

  function automatic int unsigned height_eff();
    return (lat_h_reg < 2) ? 2 : lat_h_reg;
  endfunction

  function automatic int unsigned slot_of(int unsigned r, int unsigned c);
    return (r % 3) * MAX_W + (c % MAX_W);
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    case (idx)
      REG_WIDTH:  lat_w_reg = val[WCFG_W-1:0];
      REG_HEIGHT: lat_h_reg = val[ROW_W-1:0];
      REG_VLIM:   vert_lim  = val[SCORE_W-1:0];
      REG_OLIM:   outp_lim  = val[SCORE_W-1:0];
      REG_TOL:    tol_reg   = val;
      default: ;
    endcase
  endfunction

  // Upper median: sort ascending, take index n/2.
  function automatic int upper_mid(int a[NB], int n);
    int x, j;
    for (int i = 1; i < n; i++) begin
      x = a[i];
      j = i - 1;
      while (j >= 0 && a[j] > x) begin
        a[j + 1] = a[j];
        j--;
      end
      a[j + 1] = x;
    end
    return a[n / 2];
  endfunction

  function automatic bit off_median(int val, int med);
    longint d;
    d = longint'(val) - longint'(med);
    if (d < 0) d = -d;
    return d > longint'(tol_reg);
  endfunction

  function automatic void judge_node(int unsigned r, int unsigned c, int unsigned w,
                                     int unsigned h, bit last);
    int nu[NB], nv[NB];
    int nn, nr, nc;
    int unsigned me, s;
    bit kp, ok;
    decision_t d;
    me = slot_of(r, c);
    kp = 1'b0;
    ok = 1'b0;
    nn = 0;
    if (sh_vert[me]) begin
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++) begin
          nr = int'(r) + dr;
          nc = int'(c) + dc;
          if ((dr == 0 && dc == 0) || nr < 0 || nr >= int'(h) || nc < 0 || nc >= int'(w))
            continue;
          s = slot_of(nr, nc);
          if (!sh_vert[s]) continue;
          nu[nn] = sh_u[s];
          nv[nn] = sh_v[s];
          nn++;
        end
      kp = 1'b1;
      if (nn >= MIN_NB)
        if (off_median(sh_u[me], upper_mid(nu, nn)) || off_median(sh_v[me], upper_mid(nv, nn)))
          kp = 1'b0;
      ok = kp && sh_outp[me];
    end
    if (kp) kept_run++;
    if (ok) outp_run++;
    d.row = r[ROW_W-1:0];
    d.col = c[COL_W-1:0];
    d.kept = kp;
    d.ok = ok;
    d.kcnt = kept_run;
    d.ocnt = outp_run;
    d.last = last;
    expected_nodes.insert(expected_nodes.size(), d);
  endfunction

  // Advance the shadow by one accepted node and queue the decisions it causes.
  function automatic void absorb_node(node_word_t nw);
    int unsigned w, h, r, c, me;
    w = width_eff();
    h = height_eff();
    if (pos_col >= w || pos_row >= h) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    if (r == 0 && c == 0) begin
      kept_run = '0;
      outp_run = '0;
    end
    me = slot_of(r, c);
    sh_u[me] = int'(signed'(nw.u));
    sh_v[me] = int'(signed'(nw.v));
    sh_vert[me] = nw.solved && (nw.score <= vert_lim);
    sh_outp[me] = nw.score <= outp_lim;
    if (r >= 1) begin
      if (c >= 1) judge_node(r - 1, c - 1, w, h, 1'b0);
      if (c == w - 1) judge_node(r - 1, c, w, h, 1'b0);
    end
    if (r == h - 1 && c == w - 1) begin
      for (int unsigned i = 0; i < w; i++) judge_node(r, i, w, h, i == w - 1);
      pos_row = 0;
      pos_col = 0;
    end else if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    node_word_t nw;
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        absorb_node({in_disp_u, in_disp_v, in_corr_score, in_node_solved});
        words_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          nw = pending_words.pop_front();
          in_disp_u <= nw.u;
          in_disp_v <= nw.v;
          in_corr_score <= nw.score;
          in_node_solved <= nw.solved;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Long burst now and then, short choppy bursts otherwise, each after a random gap.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap_left = $urandom_range(0, 7);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor: compare each decided node with the oldest expectation; stall on a pattern.
  int rdy_mode = 0, rdy_cnt = 0;
  always @(posedge clk) begin
    decision_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_node_row, out_node_col, out_kept, out_output_ok,
             out_kept_count, out_output_count, out_last};
      nodes_seen++;
      if (expected_nodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected node word: %p", got);
      end else begin
        want = expected_nodes.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("node mismatch: expected %p, actual %p", want, got);
        end
      end
    end
    // Hold each ready mode for a while: always ready, coin flip, mostly stalled.
    rdy_cnt++;
    if (rdy_cnt % 97 == 0) rdy_mode = $urandom_range(0, 3);
    case (rdy_mode)
      0, 1:    out_ready <= 1'b1;
      2:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Watchdog: count cycles without any handshake.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("tb: failure");
      $finish;
    end
  end

  // Hold until every queued word is taken and every decision has come out,
  // then let the sequencer drain words that decide nothing.
  task automatic drain();
    while (words_taken != words_queued || expected_nodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int vl, int ol, int tol);
    logic [TOL_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0] idx[5];
    drain();
    vals = '{TOL_W'(w), TOL_W'(h), TOL_W'(vl), TOL_W'(ol), TOL_W'(tol)};
    idx = '{REG_WIDTH, REG_HEIGHT, REG_VLIM, REG_OLIM, REG_TOL};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      shadow_write(idx[i], vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  task automatic queue_word(logic [DISP_W-1:0] u, logic [DISP_W-1:0] v,
                            logic [SCORE_W-1:0] sc, bit sv);
    pending_words.insert(pending_words.size(), {u, v, sc, sv});
    words_queued++;
  endtask

  // Smooth field with random content, some outliers and some plain noise.
  task automatic queue_field(int n, int vl, int span, bit noisy);
    logic [DISP_W-1:0] bu, bv, u, v;
    logic [SCORE_W-1:0] sc;
    bu = DISP_W'($urandom);
    bv = DISP_W'($urandom);
    for (int i = 0; i < n; i++) begin
      u = DISP_W'(bu + $urandom_range(0, 2 * span) - span);
      v = DISP_W'(bv + $urandom_range(0, 2 * span) - span);
      sc = SCORE_W'($urandom_range(0, vl));
      if (noisy || $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) u = DISP_W'($urandom);
        else v = DISP_W'($urandom);
      end
      if (noisy || $urandom_range(0, 7) == 0) sc = SCORE_W'($urandom);
      queue_word(u, v, sc, noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) != 0));
    end
  endtask

  initial begin
    int w, h, vl, ol, tol, n, span;
    for (int i = 0; i < DEPTH; i++) begin
      sh_u[i] = 0;
      sh_v[i] = 0;
      sh_vert[i] = 1'b0;
      sh_outp[i] = 1'b0;
    end
    lat_w_reg = 2;
    lat_h_reg = 2;
    vert_lim = '0;
    outp_lim = '0;
    tol_reg = '0;
    pos_row = 0;
    pos_col = 0;
    kept_run = '0;
    outp_run = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 lattice with extreme displacements, score edges and an unsolved node.
    configure(3, 3, 16'hffff, 16'h8000, 0);
    queue_word(24'h7fffff, 24'h800000, 16'h0000, 1'b1);
    queue_word(24'h000000, 24'h000000, 16'h8000, 1'b1);
    queue_word(24'h000000, 24'h000001, 16'h8001, 1'b1);
    queue_word(24'h000001, 24'h000000, 16'hffff, 1'b1);
    queue_word(24'h000000, 24'h000000, 16'h0001, 1'b1);
    queue_word(24'hffffff, 24'hffffff, 16'h0000, 1'b0);
    queue_word(24'h000000, 24'h000000, 16'h7fff, 1'b1);
    queue_word(24'h000002, 24'hfffffe, 16'h0000, 1'b1);
    queue_word(24'h800000, 24'h7fffff, 16'hffff, 1'b1);
    // Width and height below the minimum clamp to 2; zero vertex limit, widest tolerance.
    configure(0, 1, 0, 16'hffff, 23'h7fffff);
    queue_word(24'h123456, 24'hedcba9, 16'h0000, 1'b1);
    queue_word(24'h000000, 24'h000000, 16'h0001, 1'b1);
    queue_word(24'h555555, 24'haaaaaa, 16'h0000, 1'b0);
    queue_word(24'haaaaaa, 24'h555555, 16'h0000, 1'b1);
    // Tallest lattice, abandoned mid-way: the new size restarts the position.
    configure(1, 16'hffff, 16'hffff, 16'hffff, 4);
    queue_field(6, 16'hffff, 4, 1'b0);
    configure(4, 3, 16'hffff, 16'h4000, 4);
    queue_field(12, 16'hffff, 6, 1'b0);
    drain();

    // Random lattices: mostly small and well formed, a few at full width, some noise.
    while (words_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       w = 63;
        1:       w = 32;
        default: w = $urandom_range(2, 7);
      endcase
      h = (w > 8) ? 2 : $urandom_range(2, 5);
      vl = ($urandom_range(0, 4) == 0) ? 16'hffff : $urandom_range(0, 16'hffff);
      ol = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16'hffff);
      case ($urandom_range(0, 5))
        0:       tol = 0;
        1:       tol = 23'h7fffff;
        default: tol = $urandom_range(1, 512);
      endcase
      span = (tol > 4096) ? 2000 : tol + $urandom_range(0, 3);
      n = ((w > 32) ? 32 : w) * h;
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
      configure(w, h, vl, ol, tol);
      queue_field(n, vl, span, $urandom_range(0, 4) == 0);
    end
    drain();

    $display("run covered %0d node words over %0d configurations, %0d decisions checked",
             words_taken, phases_run, nodes_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
